### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_RST checks only while reset is released; ASSERT_ALWAYS checks at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### hw/rtl/stps_pkg.sv
`timescale 1ns / 1ps

package stps_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_CHOP = 2'd2;

  // Step modes
  localparam logic [1:0] MODE_FULL   = 2'd0;
  localparam logic [1:0] MODE_HALF   = 2'd1;
  localparam logic [1:0] MODE_WAVE   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOP_ON_LINES = 1'b1;

  localparam logic [1:0] STEP_MODE_RST = MODE_WAVE;

  // Comparator bits
  localparam int CMP_AB_BIT = 0;
  localparam int CMP_CD_BIT = 1;

  // Drive line bits: A,B,C,D,ABinh,CDinh from MSB to LSB
  localparam logic [5:0] DRV_AB_PHASE = 6'h30;
  localparam logic [5:0] DRV_CD_PHASE = 6'h0C;
  localparam logic [5:0] DRV_AB_INH   = 6'h02;
  localparam logic [5:0] DRV_CD_INH   = 6'h01;

  typedef struct packed {
    logic [1:0] step_mode;
    logic       chop_on_lines;
  } stps_cfg_t;

  typedef struct packed {
    logic [2:0]         phase_index;
    logic signed [15:0] pending;
    logic [5:0]         drive;
  } stps_state_t;

  function automatic logic [5:0] drive_pattern(input logic [2:0] idx);
    logic [5:0] pat;
    case (idx)
      3'd0:    pat = 6'h17;
      3'd1:    pat = 6'h05;
      3'd2:    pat = 6'h27;
      3'd3:    pat = 6'h22;
      3'd4:    pat = 6'h2B;
      3'd5:    pat = 6'h09;
      3'd6:    pat = 6'h1B;
      default: pat = 6'h12;
    endcase
    return pat;
  endfunction

  function automatic logic [2:0] next_index(input logic [1:0] mode, input logic [2:0] idx,
                                            input logic fwd);
    logic [3:0] sum;
    logic [2:0] res;
    sum = {1'b0, idx} + 4'd2;
    case (mode)
      MODE_HALF: begin
        res = fwd ? idx + 3'd1 : idx - 3'd1;
      end
      MODE_FULL: begin
        if (fwd) res = (sum > 4'd6) ? 3'd0 : sum[2:0];
        else     res = (idx < 3'd2) ? 3'd6 : idx - 3'd2;
      end
      default: begin
        if (fwd) res = (sum > 4'd7) ? 3'd1 : sum[2:0];
        else     res = (idx < 3'd3) ? 3'd7 : idx - 3'd2;
      end
    endcase
    return res;
  endfunction

endpackage

### hw/rtl/stps_ifs.sv
`timescale 1ns / 1ps

interface stps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] step_count;
  logic [1:0]         comparator_bits;

  modport source (output valid, command, step_count, comparator_bits, input ready);
  modport sink   (input valid, command, step_count, comparator_bits, output ready);
endinterface

interface stps_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         phase_lines;
  logic               ab_enable;
  logic               cd_enable;
  logic signed [15:0] steps_left;
  logic               moving;

  modport source (output valid, phase_lines, ab_enable, cd_enable, steps_left, moving,
                  input ready);
  modport sink   (input valid, phase_lines, ab_enable, cd_enable, steps_left, moving,
                  output ready);
endinterface

### hw/rtl/stepper_phase_sequencer_unit.sv
// Stepper phase sequencer: full, half and wave step indexer with chop control.
// The result of an accepted item is registered and shows on out_ch in the next cycle.
// Throughput: one item per cycle while out_ch is ready; the output register frees as it is taken.
// Reset (rst_n low, synchronous): phase index, pending count and drive lines clear,
// step_mode returns to wave, chop_on_lines to 0, and no result is pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stepper_phase_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [stps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  stps_in_if.sink                          in_ch,
  stps_out_if.source                       out_ch
);
  import stps_pkg::*;

  // Configuration registers
  stps_cfg_t   cfg_r;

  // Sequencer state: phase index, pending signed count, six drive lines
  stps_state_t state_r;
  stps_state_t state_nxt;

  // Result register
  logic               out_valid_r;
  logic [3:0]         phase_lines_r;
  logic               ab_enable_r;
  logic               cd_enable_r;
  logic signed [15:0] steps_left_r;
  logic               moving_r;

  logic in_fire;

  // Qualified accepts used by the checks below
  logic load_fire;
  logic live_tick;
  logic full_even_fire;

  // Take a new item whenever the result register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration writes land directly; the host must write only while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_mode     <= STEP_MODE_RST;
      cfg_r.chop_on_lines <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_MODE:     cfg_r.step_mode     <= cfg_wdata;
        REG_CHOP_ON_LINES: cfg_r.chop_on_lines <= cfg_wdata[0];
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  // All per-item work: tick, load or chop against the current state
  stps_next u_next (
    .cfg             (cfg_r),
    .state           (state_r),
    .command         (in_ch.command),
    .step_count      (in_ch.step_count),
    .comparator_bits (in_ch.comparator_bits),
    .state_nxt       (state_nxt)
  );

  // Advance the state only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase_index <= 3'd0;
      state_r.pending     <= 16'sd0;
      state_r.drive       <= 6'd0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result valid: set by an accepted item, dropped when taken with nothing new
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: the state as left by the item; hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      phase_lines_r <= state_nxt.drive[5:2];
      ab_enable_r   <= state_nxt.drive[1];
      cd_enable_r   <= state_nxt.drive[0];
      steps_left_r  <= state_nxt.pending;
      moving_r      <= (state_nxt.pending != 16'sd0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.phase_lines = phase_lines_r;
  assign out_ch.ab_enable   = ab_enable_r;
  assign out_ch.cd_enable   = cd_enable_r;
  assign out_ch.steps_left  = steps_left_r;
  assign out_ch.moving      = moving_r;

  assign load_fire      = in_fire && (in_ch.command == CMD_LOAD);
  assign live_tick      = in_fire && (in_ch.command == CMD_TICK) &&
                          (cfg_r.step_mode != MODE_UNUSED) && (state_r.pending != 16'sd0);
  assign full_even_fire = in_fire && (cfg_r.step_mode == MODE_FULL) && !state_r.phase_index[0];

  // A load shows up as the next result's pending count
  `ASSERT_RST(a_load_result, clk, rst_n, load_fire |=> (steps_left_r == $past(in_ch.step_count)))

  // A live tick always moves the pending count
  `ASSERT_RST(a_tick_moves, clk, rst_n, live_tick |=> (state_r.pending != $past(state_r.pending)))

  // Full steps from an even index stay on even indexes
  `ASSERT_RST(a_full_even, clk, rst_n, full_even_fire |=> !state_r.phase_index[0])

  // Reset empties the result register
  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid_r)

endmodule

### hw/rtl/stps_next.sv
`timescale 1ns / 1ps

module stps_next (
  input  stps_pkg::stps_cfg_t   cfg,
  input  stps_pkg::stps_state_t state,
  input  logic [1:0]            command,
  input  logic signed [15:0]    step_count,
  input  logic [1:0]            comparator_bits,
  output stps_pkg::stps_state_t state_nxt
);
  import stps_pkg::*;

  logic       fwd;
  logic       parity_ok;
  logic       tick_live;
  logic [2:0] idx_nxt;

  assign fwd       = !state.pending[15];
  assign tick_live = (cfg.step_mode != MODE_UNUSED) && (state.pending != 16'sd0);
  assign idx_nxt   = next_index(cfg.step_mode, state.phase_index, fwd);

  always_comb begin
    case (cfg.step_mode)
      MODE_FULL: parity_ok = !state.phase_index[0];
      MODE_WAVE: parity_ok = state.phase_index[0];
      default:   parity_ok = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state;
    unique case (command)
      CMD_TICK: begin
        if (tick_live) begin
          state_nxt.phase_index = idx_nxt;
          if (parity_ok) state_nxt.drive = drive_pattern(idx_nxt);
          state_nxt.pending = fwd ? state.pending - 16'sd1 : state.pending + 16'sd1;
        end
      end
      CMD_LOAD: begin
        state_nxt.pending = step_count;
      end
      CMD_CHOP: begin
        // CD side wins when both comparators trip
        if (comparator_bits[CMP_CD_BIT]) begin
          state_nxt.drive = state.drive & ~(cfg.chop_on_lines ? DRV_CD_PHASE : DRV_CD_INH);
        end else if (comparator_bits[CMP_AB_BIT]) begin
          state_nxt.drive = state.drive & ~(cfg.chop_on_lines ? DRV_AB_PHASE : DRV_AB_INH);
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import stps_pkg::*;

  // Code the package leaves unnamed: the spare command.
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // Drive word per phase index, lines A,B,C,D,ABinh,CDinh from bit 5 down to bit 0.
  localparam logic [5:0] PHASE_DRIVE [8] = '{
    6'h17, 6'h05, 6'h27, 6'h22, 6'h2B, 6'h09, 6'h1B, 6'h12
  };

  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 125;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int SETTLE_CYCLES    = 2;

  // Step mode for each random phase; the first four keep chop on the inhibit
  // lines, the last four chop on the phase lines.
  localparam logic [1:0] PHASE_MODES [RANDOM_PHASES] = '{
    MODE_FULL, MODE_HALF, MODE_WAVE, MODE_UNUSED,
    MODE_FULL, MODE_HALF, MODE_WAVE, MODE_FULL
  };

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] step_count;
    logic [1:0]         comparator_bits;
  } step_cmd_t;

  typedef struct packed {
    logic [3:0]         phase_lines;
    logic               ab_enable;
    logic               cd_enable;
    logic signed [15:0] steps_left;
    logic               moving;
  } drive_state_t;

  // One row of the directed script. A row with new_cfg set first waits for the
  // block to drain and then writes both registers. A row with fixed set carries
  // its expected result; all others take the predicted one.
  typedef struct packed {
    logic               new_cfg;
    logic [1:0]         mode;
    logic [1:0]         chop_word;
    logic [1:0]         command;
    logic signed [15:0] step_count;
    logic [1:0]         cmp_bits;
    logic               fixed;
    logic [3:0]         f_lines;
    logic               f_ab;
    logic               f_cd;
    logic signed [15:0] f_left;
    logic               f_moving;
  } script_row_t;

  localparam int SCRIPT_LEN = 26;

  //  cfg   mode       chop   command     count     cmp    fix   lines ab    cd    left     mov
  localparam script_row_t DIRECTED [SCRIPT_LEN] = '{
    // Right after reset: wave mode, chop on inhibit lines, all lines dark.
    '{1'b0, MODE_WAVE, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b1, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_WAVE, 2'd0, CMD_UNUSED, 16'hFFFF, 2'd3, 1'b1, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_WAVE, 2'd0, CMD_CHOP,   16'h0000, 2'd3, 1'b1, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_WAVE, 2'd0, CMD_LOAD,   16'h7FFF, 2'd0, 1'b1, 4'h0, 1'b0, 1'b0, 16'h7FFF, 1'b1},
    '{1'b0, MODE_WAVE, 2'd0, CMD_LOAD,   16'h8000, 2'd3, 1'b1, 4'h0, 1'b0, 1'b0, 16'h8000, 1'b1},
    // Wave mode from an even index: the first tick moves the index and holds the lines, later ticks change both.
    '{1'b0, MODE_WAVE, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_WAVE, 2'd0, CMD_TICK,   16'hFFFF, 2'd3, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_WAVE, 2'd0, CMD_LOAD,   16'h0003, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_WAVE, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_WAVE, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_WAVE, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // Nothing left to step: the tick changes nothing.
    '{1'b0, MODE_WAVE, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // Full step, backward, then chop each inhibit line.
    '{1'b1, MODE_FULL, 2'd0, CMD_LOAD,   16'hFFFB, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_FULL, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_FULL, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_FULL, 2'd0, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_FULL, 2'd0, CMD_CHOP,   16'h0000, 2'd1, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_FULL, 2'd0, CMD_CHOP,   16'h0000, 2'd2, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // Half step, chop on phase lines; the upper data bit of the chop write is noise.
    '{1'b1, MODE_HALF, 2'd3, CMD_LOAD,   16'h0002, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_HALF, 2'd3, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // Both comparator bits set: only the CD side chops.
    '{1'b0, MODE_HALF, 2'd3, CMD_CHOP,   16'h0000, 2'd3, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_HALF, 2'd3, CMD_TICK,   16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_HALF, 2'd3, CMD_CHOP,   16'h0000, 2'd1, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // Spare step mode: ticks leave everything alone, the count included.
    '{1'b1, MODE_UNUSED, 2'd2, CMD_LOAD, 16'h0007, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, MODE_UNUSED, 2'd2, CMD_TICK, 16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // Chop with no comparator bit set: nothing changes.
    '{1'b0, MODE_UNUSED, 2'd2, CMD_CHOP, 16'h0000, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0, 16'h0000, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  stps_in_if  in_ch ();
  stps_out_if out_ch ();

  stepper_phase_sequencer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the sequencer: registers and state as the block should hold them.
  logic [1:0]         seq_mode;
  logic               seq_chop;
  logic [2:0]         seq_index;
  logic signed [15:0] seq_pending;
  logic [5:0]         seq_drive;

  drive_state_t expected_drive_q[$];

  int n_errors   = 0;
  int n_items    = 0;
  int n_checked  = 0;
  int n_cfg      = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left    = 0;

  // Apply one command to the mirror and return the outputs it leaves behind.
  function automatic drive_state_t step_sequencer(input step_cmd_t cmd);
    drive_state_t res;
    logic         fwd;
    logic         aligned;
    logic         lane;
    logic [2:0]   top_idx;
    logic [2:0]   low_idx;
    logic [3:0]   lifted;
    case (cmd.command)
      CMD_TICK: begin
        if (seq_mode != MODE_UNUSED && seq_pending != 16'sd0) begin
          fwd = !seq_pending[15];
          // Full steps live on the even indexes and wave steps on the odd ones;
          // off its lane a tick still moves the index but leaves the lines alone.
          aligned = (seq_mode == MODE_FULL) ? !seq_index[0] :
                    (seq_mode == MODE_WAVE) ?  seq_index[0] : 1'b1;
          if (seq_mode == MODE_HALF) begin
            seq_index = fwd ? seq_index + 3'd1 : seq_index - 3'd1;
          end else begin
            // Move by two and wrap within the lane.
            lane    = (seq_mode == MODE_WAVE);
            top_idx = lane ? 3'd7 : 3'd6;
            low_idx = lane ? 3'd1 : 3'd0;
            if (fwd) begin
              lifted    = {1'b0, seq_index} + 4'd2;
              seq_index = (lifted > {1'b0, top_idx}) ? low_idx : lifted[2:0];
            end else begin
              seq_index = (seq_index < low_idx + 3'd2) ? top_idx : seq_index - 3'd2;
            end
          end
          if (aligned) seq_drive = PHASE_DRIVE[seq_index];
          seq_pending = fwd ? seq_pending - 16'sd1 : seq_pending + 16'sd1;
        end
      end
      CMD_LOAD: seq_pending = cmd.step_count;
      CMD_CHOP: begin
        // CD takes priority over AB when both comparators trip.
        if (cmd.comparator_bits[CMP_CD_BIT])
          seq_drive = seq_drive & ~(seq_chop ? DRV_CD_PHASE : DRV_CD_INH);
        else if (cmd.comparator_bits[CMP_AB_BIT])
          seq_drive = seq_drive & ~(seq_chop ? DRV_AB_PHASE : DRV_AB_INH);
      end
      default: ;
    endcase
    res.phase_lines = seq_drive[5:2];
    res.ab_enable   = seq_drive[1];
    res.cd_enable   = seq_drive[0];
    res.steps_left  = seq_pending;
    res.moving      = (seq_pending != 16'sd0);
    return res;
  endfunction

  // Mostly well-formed motion: short loads followed by runs of ticks, with
  // chop events mixed in; the rest is spare commands and full-range loads.
  function automatic step_cmd_t pick_command();
    step_cmd_t  cmd;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    cmd.step_count      = 16'($urandom);
    cmd.comparator_bits = 2'($urandom);
    if (roll < 60) begin
      cmd.command = CMD_TICK;
    end else if (roll < 75) begin
      cmd.command = CMD_LOAD;
      if ($urandom_range(0, 7) != 0)
        cmd.step_count = 16'($urandom_range(0, 80)) - 16'd40;
    end else if (roll < 95) begin
      cmd.command = CMD_CHOP;
    end else begin
      cmd.command = CMD_UNUSED;
    end
    return cmd;
  endfunction

  // Offer one item, hold it until taken, record what it should produce, then
  // by chance idle the sender for a random gap.
  task automatic offer_item(input step_cmd_t cmd, input logic fixed,
                            input drive_state_t fixed_res);
    drive_state_t predicted;
    in_ch.valid           <= 1'b1;
    in_ch.command         <= cmd.command;
    in_ch.step_count      <= cmd.step_count;
    in_ch.comparator_bits <= cmd.comparator_bits;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predicted = step_sequencer(cmd);
    expected_drive_q.push_back(fixed ? fixed_res : predicted);
    n_items++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_drive_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; only called while the block is idle.
  task automatic write_config(input logic [1:0] mode, input logic [1:0] chop_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_MODE;
    cfg_wdata <= mode;
    @(posedge clk);
    seq_mode  = mode;
    cfg_index <= REG_CHOP_ON_LINES;
    cfg_wdata <= chop_word;
    @(posedge clk);
    seq_chop  = chop_word[0];
    cfg_we    <= 1'b0;
    n_cfg += 2;
    @(posedge clk);
  endtask

  task automatic flag_field(input string name, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    n_errors++;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Result checker: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    drive_state_t want;
    drive_state_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.phase_lines, out_ch.ab_enable, out_ch.cd_enable,
              out_ch.steps_left, out_ch.moving};
      if (expected_drive_q.size() == 0) begin
        $display("%0t: result with nothing expected, got lines %h steps_left %0d",
                 $time, got.phase_lines, got.steps_left);
        n_errors++;
      end else begin
        want = expected_drive_q.pop_front();
        n_checked++;
        if (got.phase_lines !== want.phase_lines)
          flag_field("phase_lines", want.phase_lines, got.phase_lines);
        if (got.ab_enable !== want.ab_enable)
          flag_field("ab_enable", want.ab_enable, got.ab_enable);
        if (got.cd_enable !== want.cd_enable)
          flag_field("cd_enable", want.cd_enable, got.cd_enable);
        if (got.steps_left !== want.steps_left)
          flag_field("steps_left", want.steps_left, got.steps_left);
        if (got.moving !== want.moving)
          flag_field("moving", want.moving, got.moving);
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    int          row;
    int          ph;
    int          k;
    step_cmd_t   cmd;
    drive_state_t fixed_res;

    // Drive every input to a known value and hold reset.
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.command         <= CMD_TICK;
    in_ch.step_count      <= '0;
    in_ch.comparator_bits <= '0;

    // Mirror starts in the reset state: wave mode, chop on inhibit lines.
    seq_mode    = STEP_MODE_RST;
    seq_chop    = 1'b0;
    seq_index   = '0;
    seq_pending = '0;
    seq_drive   = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script with light idling on both sides.
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    for (row = 0; row < SCRIPT_LEN; row++) begin
      if (DIRECTED[row].new_cfg) begin
        drain_results();
        write_config(DIRECTED[row].mode, DIRECTED[row].chop_word);
      end
      cmd       = '{DIRECTED[row].command, DIRECTED[row].step_count, DIRECTED[row].cmp_bits};
      fixed_res = '{DIRECTED[row].f_lines, DIRECTED[row].f_ab, DIRECTED[row].f_cd,
                    DIRECTED[row].f_left, DIRECTED[row].f_moving};
      offer_item(cmd, DIRECTED[row].fixed, fixed_res);
    end

    // Random phases: each drains, reconfigures, and picks an idle mix.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      write_config(PHASE_MODES[ph], {1'($urandom_range(0, 1)), (ph >= RANDOM_PHASES / 2)});
      // First phase: hold the receiver off while the sender keeps offering,
      // so the block backs up and stalls its input.
      if (ph == 0) hold_left = HOLD_OFF_CYCLES;
      for (k = 0; k < ITEMS_PER_PHASE; k++)
        offer_item(pick_command(), 1'b0, '0);
    end

    drain_results();

    $display("run: %0d items sent, %0d results checked, %0d register writes, %0d errors",
             n_items, n_checked, n_cfg, n_errors);
    $display("run: all step modes, both chop styles, four idle mixes, one long hold-off");
    if (n_errors == 0 && expected_drive_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
